/* hw/rtl/jmre_pkg.sv */
`default_nettype none

package jmre_pkg;

  localparam int unsigned RingDepthDef  = 16;
  localparam int unsigned CalSamplesDef = 50;

  localparam int unsigned SampleW = 12;
  localparam int unsigned SumW    = 18;
  localparam int unsigned CntW    = 6;
  localparam int unsigned DivW    = 18;
  localparam int unsigned DsrW    = 8;
  localparam int unsigned BandW   = 11;
  localparam int unsigned LimW    = 7;
  localparam int unsigned MoveW   = 8;
  localparam int unsigned CodeW   = 8;
  localparam int unsigned BtnW    = 3;
  localparam int unsigned CfgW    = 11;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [BandW-1:0]   DeadBandRst = 11'd150;
  localparam logic [DsrW-1:0]    SpeedDivRst = 8'd20;
  localparam logic [LimW-1:0]    SpeedLimRst = 7'd127;
  localparam logic [SampleW-1:0] CentreRst   = 12'd2048;

  localparam logic [CodeW-1:0] EvLeftPress    = 8'h10;
  localparam logic [CodeW-1:0] EvLeftRelease  = 8'h11;
  localparam logic [CodeW-1:0] EvRightPress   = 8'h20;
  localparam logic [CodeW-1:0] EvRightRelease = 8'h21;
  localparam logic [CodeW-1:0] EvMidPress     = 8'h30;
  localparam logic [CodeW-1:0] EvMidRelease   = 8'h31;

  localparam logic [1:0] BtnLeft   = 2'd0;
  localparam logic [1:0] BtnRight  = 2'd1;
  localparam logic [1:0] BtnMiddle = 2'd2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEAD_BAND = 2'd0,
    REG_SPEED_DIV = 2'd1,
    REG_SPEED_LIM = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_DRAIN  = 1'b1
  } op_e;

  typedef enum logic {
    KIND_REPORT = 1'b0,
    KIND_EVENT  = 1'b1
  } kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_AVG_X,
    S_AVG_Y,
    S_MOT_GO_X,
    S_MOT_X,
    S_MOT_GO_Y,
    S_MOT_Y,
    S_PUSH,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic               operation;
    logic               link_ready;
    logic [SampleW-1:0] x_sample;
    logic [SampleW-1:0] y_sample;
    logic               left_level;
    logic               right_level;
    logic               middle_level;
  } in_item_t;

  typedef struct packed {
    logic                    result_kind;
    logic [BtnW-1:0]         button_bits;
    logic signed [MoveW-1:0] x_move;
    logic signed [MoveW-1:0] y_move;
    logic [CodeW-1:0]        event_code;
  } out_item_t;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DsrW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quot;
  } div_res_t;

  function automatic logic [CodeW-1:0] ev_code(input logic [1:0] btn, input logic pressed);
    logic [CodeW-1:0] code;
    unique case (btn)
      BtnLeft:   code = pressed ? EvLeftPress  : EvLeftRelease;
      BtnRight:  code = pressed ? EvRightPress : EvRightRelease;
      BtnMiddle: code = pressed ? EvMidPress   : EvMidRelease;
      default:   code = '0;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/jmre_div.sv */
`default_nettype none

module jmre_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  jmre_pkg::div_req_t req_i,
  output jmre_pkg::div_res_t res_o
);

  localparam int unsigned StepW = $clog2(jmre_pkg::DivW + 1);

  logic [StepW-1:0]          step_d, step_q;
  logic                      done_d, done_q;
  logic [jmre_pkg::DivW-1:0] dvd_d, dvd_q;
  logic [jmre_pkg::DsrW-1:0] dsr_d, dsr_q;
  logic [jmre_pkg::DsrW-1:0] rem_d, rem_q;
  logic [jmre_pkg::DsrW:0]   rem_sh, rem_sub;

  always_comb begin
    rem_sh  = {rem_q, dvd_q[jmre_pkg::DivW-1]};
    rem_sub = rem_sh - {1'b0, dsr_q};
    step_d  = step_q;
    done_d  = 1'b0;
    dvd_d   = dvd_q;
    dsr_d   = dsr_q;
    rem_d   = rem_q;
    if (req_i.start) begin
      step_d = StepW'(jmre_pkg::DivW);
      dvd_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
      rem_d  = '0;
    end else if (step_q != '0) begin
      step_d = step_q - 1'b1;
      done_d = (step_q == StepW'(1));
      if (rem_sh >= {1'b0, dsr_q}) begin
        rem_d = rem_sub[jmre_pkg::DsrW-1:0];
        dvd_d = {dvd_q[jmre_pkg::DivW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[jmre_pkg::DsrW-1:0];
        dvd_d = {dvd_q[jmre_pkg::DivW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign res_o.done = done_q;
  assign res_o.quot = dvd_q;

endmodule

`default_nettype wire

/* hw/rtl/joystick_mouse_report_engine_core.sv */
// Report path: S_MOT_GO_X and S_MOT_X launch and run the shared bit-serial divider for
// X, S_MOT_GO_Y and S_MOT_Y for Y, S_PUSH takes three event push steps, and S_FINISH
// registers the output, waiting while an earlier result is not taken. A drain item
// reads its event into S_FINISH. Ignored items give no result; the sample that ends
// calibration runs both averaging divisions, no result. One item is taken at a time.
// Reset: asynchronous, restores registers and state; ring contents are not cleared.
`default_nettype none

module joystick_mouse_report_engine_core #(
  parameter int unsigned RING_DEPTH          = jmre_pkg::RingDepthDef,
  parameter int unsigned CALIBRATION_SAMPLES = jmre_pkg::CalSamplesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  jmre_pkg::in_item_t           in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output jmre_pkg::out_item_t          out_data_o,
  input  logic                         cfg_we_i,
  input  logic [jmre_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [jmre_pkg::CfgW-1:0]    cfg_data_i
);

  localparam int unsigned PtrW = $clog2(RING_DEPTH);

  jmre_pkg::state_e state_d, state_q;

  logic [jmre_pkg::BandW-1:0]   dead_band_d, dead_band_q;
  logic [jmre_pkg::DsrW-1:0]    speed_div_d, speed_div_q;
  logic [jmre_pkg::LimW-1:0]    speed_lim_d, speed_lim_q;

  logic [jmre_pkg::SampleW-1:0] centre_x_d, centre_x_q, centre_y_d, centre_y_q;
  logic                         calib_d, calib_q;
  logic [jmre_pkg::SumW-1:0]    sum_x_d, sum_x_q, sum_y_d, sum_y_q;
  logic [jmre_pkg::CntW-1:0]    cal_cnt_d, cal_cnt_q;
  logic [jmre_pkg::BtnW-1:0]    btn_prev_d, btn_prev_q;
  logic [PtrW-1:0]              wr_slot_d, wr_slot_q, rd_slot_d, rd_slot_q;
  logic [1:0]                   btn_idx_d, btn_idx_q;
  logic                         out_valid_d, out_valid_q;

  logic [jmre_pkg::SampleW-1:0]   x_d, x_q, y_d, y_q;
  logic [jmre_pkg::BtnW-1:0]      btn_now_d, btn_now_q;
  logic                           neg_d, neg_q;
  logic signed [jmre_pkg::MoveW-1:0] mv_x_d, mv_x_q, mv_y_d, mv_y_q;
  logic                           kind_d, kind_q;
  jmre_pkg::out_item_t            out_d, out_q;

  logic [jmre_pkg::CodeW-1:0] ring_q [RING_DEPTH];
  logic [jmre_pkg::CodeW-1:0] rd_data_q;
  logic                       ring_we, ring_re;
  logic [jmre_pkg::CodeW-1:0] ring_wdata;
  logic [PtrW-1:0]            wr_next, rd_next;
  logic                       ring_full, ring_empty;

  jmre_pkg::div_req_t div_req;
  jmre_pkg::div_res_t div_res;

  logic                          in_xfer, cal_last;
  logic [jmre_pkg::CntW:0]       cal_cnt_inc;
  logic [jmre_pkg::DsrW-1:0]     dsr_eff;
  logic [jmre_pkg::SampleW-1:0]  axis_smp, axis_ctr, axis_mag, axis_excess;
  logic [jmre_pkg::SampleW:0]    axis_diff;
  logic                          axis_neg;
  logic [jmre_pkg::LimW-1:0]     mv_mag;
  logic signed [jmre_pkg::MoveW-1:0] mv_clamped;

  jmre_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .res_o  (div_res)
  );

  assign in_ready_o  = (state_q == jmre_pkg::S_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign wr_next    = (wr_slot_q == PtrW'(RING_DEPTH - 1)) ? '0 : wr_slot_q + 1'b1;
  assign rd_next    = (rd_slot_q == PtrW'(RING_DEPTH - 1)) ? '0 : rd_slot_q + 1'b1;
  assign ring_full  = (wr_next == rd_slot_q);
  assign ring_empty = (wr_slot_q == rd_slot_q);

  assign cal_cnt_inc = {1'b0, cal_cnt_q} + 1'b1;
  assign cal_last    = (cal_cnt_inc >= (jmre_pkg::CntW + 1)'(CALIBRATION_SAMPLES));
  assign dsr_eff     = (speed_div_q == '0) ? jmre_pkg::DsrW'(1) : speed_div_q;

  assign axis_smp    = (state_q == jmre_pkg::S_MOT_GO_Y) ? y_q : x_q;
  assign axis_ctr    = (state_q == jmre_pkg::S_MOT_GO_Y) ? centre_y_q : centre_x_q;
  assign axis_diff   = {1'b0, axis_smp} - {1'b0, axis_ctr};
  assign axis_neg    = axis_diff[jmre_pkg::SampleW];
  assign axis_mag    = axis_neg ? jmre_pkg::SampleW'(-axis_diff)
                                : axis_diff[jmre_pkg::SampleW-1:0];
  assign axis_excess = (axis_mag > {1'b0, dead_band_q})
                       ? axis_mag - {1'b0, dead_band_q} : '0;

  assign mv_mag     = (div_res.quot > jmre_pkg::DivW'(speed_lim_q))
                      ? speed_lim_q : div_res.quot[jmre_pkg::LimW-1:0];
  assign mv_clamped = neg_q ? -$signed({1'b0, mv_mag}) : $signed({1'b0, mv_mag});

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      jmre_pkg::S_IDLE: begin
        if (in_xfer && in_data_i.link_ready) begin
          if (in_data_i.operation == jmre_pkg::OP_DRAIN) begin
            if (!ring_empty) begin
              state_d = jmre_pkg::S_FINISH;
            end
          end else if (!calib_q) begin
            if (cal_last) begin
              state_d = jmre_pkg::S_AVG_X;
            end
          end else begin
            state_d = jmre_pkg::S_MOT_GO_X;
          end
        end
      end
      jmre_pkg::S_AVG_X: begin
        if (div_res.done) begin
          state_d = jmre_pkg::S_AVG_Y;
        end
      end
      jmre_pkg::S_AVG_Y: begin
        if (div_res.done) begin
          state_d = jmre_pkg::S_IDLE;
        end
      end
      jmre_pkg::S_MOT_GO_X: begin
        state_d = jmre_pkg::S_MOT_X;
      end
      jmre_pkg::S_MOT_X: begin
        if (div_res.done) begin
          state_d = jmre_pkg::S_MOT_GO_Y;
        end
      end
      jmre_pkg::S_MOT_GO_Y: begin
        state_d = jmre_pkg::S_MOT_Y;
      end
      jmre_pkg::S_MOT_Y: begin
        if (div_res.done) begin
          state_d = jmre_pkg::S_PUSH;
        end
      end
      jmre_pkg::S_PUSH: begin
        if (btn_idx_q == jmre_pkg::BtnMiddle) begin
          state_d = jmre_pkg::S_FINISH;
        end
      end
      jmre_pkg::S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = jmre_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = jmre_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    dead_band_d = dead_band_q;
    speed_div_d = speed_div_q;
    speed_lim_d = speed_lim_q;
    centre_x_d  = centre_x_q;
    centre_y_d  = centre_y_q;
    calib_d     = calib_q;
    sum_x_d     = sum_x_q;
    sum_y_d     = sum_y_q;
    cal_cnt_d   = cal_cnt_q;
    btn_prev_d  = btn_prev_q;
    wr_slot_d   = wr_slot_q;
    rd_slot_d   = rd_slot_q;
    btn_idx_d   = btn_idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    x_d         = x_q;
    y_d         = y_q;
    btn_now_d   = btn_now_q;
    neg_d       = neg_q;
    mv_x_d      = mv_x_q;
    mv_y_d      = mv_y_q;
    kind_d      = kind_q;
    out_d       = out_q;
    ring_we     = 1'b0;
    ring_re     = 1'b0;
    ring_wdata  = jmre_pkg::ev_code(btn_idx_q, btn_now_q[btn_idx_q]);
    div_req     = '{start: 1'b0, dividend: sum_y_q, divisor: dsr_eff};

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        jmre_pkg::REG_DEAD_BAND: dead_band_d = cfg_data_i[jmre_pkg::BandW-1:0];
        jmre_pkg::REG_SPEED_DIV: speed_div_d = cfg_data_i[jmre_pkg::DsrW-1:0];
        jmre_pkg::REG_SPEED_LIM: speed_lim_d = cfg_data_i[jmre_pkg::LimW-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      jmre_pkg::S_IDLE: begin
        if (in_xfer && in_data_i.link_ready) begin
          if (in_data_i.operation == jmre_pkg::OP_DRAIN) begin
            if (!ring_empty) begin
              ring_re   = 1'b1;
              rd_slot_d = rd_next;
              kind_d    = jmre_pkg::KIND_EVENT;
            end
          end else if (!calib_q) begin
            sum_x_d   = sum_x_q + jmre_pkg::SumW'(in_data_i.x_sample);
            sum_y_d   = sum_y_q + jmre_pkg::SumW'(in_data_i.y_sample);
            cal_cnt_d = cal_cnt_inc[jmre_pkg::CntW-1:0];
            if (cal_last) begin
              div_req = '{start: 1'b1, dividend: sum_x_d,
                          divisor: jmre_pkg::DsrW'(CALIBRATION_SAMPLES)};
            end
          end else begin
            x_d       = in_data_i.x_sample;
            y_d       = in_data_i.y_sample;
            btn_now_d = ~{in_data_i.middle_level, in_data_i.right_level,
                          in_data_i.left_level};
            kind_d    = jmre_pkg::KIND_REPORT;
          end
        end
      end
      jmre_pkg::S_AVG_X: begin
        if (div_res.done) begin
          centre_x_d = div_res.quot[jmre_pkg::SampleW-1:0];
          div_req    = '{start: 1'b1, dividend: sum_y_q,
                         divisor: jmre_pkg::DsrW'(CALIBRATION_SAMPLES)};
        end
      end
      jmre_pkg::S_AVG_Y: begin
        if (div_res.done) begin
          centre_y_d = div_res.quot[jmre_pkg::SampleW-1:0];
          calib_d    = 1'b1;
        end
      end
      jmre_pkg::S_MOT_GO_X, jmre_pkg::S_MOT_GO_Y: begin
        neg_d   = axis_neg;
        div_req = '{start: 1'b1, dividend: jmre_pkg::DivW'(axis_excess), divisor: dsr_eff};
      end
      jmre_pkg::S_MOT_X: begin
        if (div_res.done) begin
          mv_x_d = mv_clamped;
        end
      end
      jmre_pkg::S_MOT_Y: begin
        if (div_res.done) begin
          mv_y_d = mv_clamped;
        end
      end
      jmre_pkg::S_PUSH: begin
        if ((btn_now_q[btn_idx_q] != btn_prev_q[btn_idx_q]) && !ring_full) begin
          ring_we   = 1'b1;
          wr_slot_d = wr_next;
        end
        if (btn_idx_q == jmre_pkg::BtnMiddle) begin
          btn_idx_d  = '0;
          btn_prev_d = btn_now_q;
        end else begin
          btn_idx_d = btn_idx_q + 1'b1;
        end
      end
      jmre_pkg::S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          if (kind_q == jmre_pkg::KIND_EVENT) begin
            out_d = '{result_kind: jmre_pkg::KIND_EVENT, button_bits: '0,
                      x_move: '0, y_move: '0, event_code: rd_data_q};
          end else begin
            out_d = '{result_kind: jmre_pkg::KIND_REPORT, button_bits: btn_now_q,
                      x_move: mv_x_q, y_move: mv_y_q, event_code: '0};
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= jmre_pkg::S_IDLE;
      dead_band_q <= jmre_pkg::DeadBandRst;
      speed_div_q <= jmre_pkg::SpeedDivRst;
      speed_lim_q <= jmre_pkg::SpeedLimRst;
      centre_x_q  <= jmre_pkg::CentreRst;
      centre_y_q  <= jmre_pkg::CentreRst;
      calib_q     <= 1'b0;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      cal_cnt_q   <= '0;
      btn_prev_q  <= '0;
      wr_slot_q   <= '0;
      rd_slot_q   <= '0;
      btn_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dead_band_q <= dead_band_d;
      speed_div_q <= speed_div_d;
      speed_lim_q <= speed_lim_d;
      centre_x_q  <= centre_x_d;
      centre_y_q  <= centre_y_d;
      calib_q     <= calib_d;
      sum_x_q     <= sum_x_d;
      sum_y_q     <= sum_y_d;
      cal_cnt_q   <= cal_cnt_d;
      btn_prev_q  <= btn_prev_d;
      wr_slot_q   <= wr_slot_d;
      rd_slot_q   <= rd_slot_d;
      btn_idx_q   <= btn_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q       <= x_d;
    y_q       <= y_d;
    btn_now_q <= btn_now_d;
    neg_q     <= neg_d;
    mv_x_q    <= mv_x_d;
    mv_y_q    <= mv_y_d;
    kind_q    <= kind_d;
    out_q     <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_q[wr_slot_q] <= ring_wdata;
    end
    if (ring_re) begin
      rd_data_q <= ring_q[rd_slot_q];
    end
  end

`ifndef SYNTH
  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> (state_q == jmre_pkg::S_AVG_X || state_q == jmre_pkg::S_AVG_Y ||
                      state_q == jmre_pkg::S_MOT_X || state_q == jmre_pkg::S_MOT_Y))
    else $error("Divider finished outside a wait state.");

  a_calib_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    calib_q |=> calib_q)
    else $error("Calibration flag cleared without reset.");

  a_cal_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !calib_q |-> ({1'b0, cal_cnt_q} <= (jmre_pkg::CntW + 1)'(CALIBRATION_SAMPLES)))
    else $error("Calibration count passed its end.");

  a_finish_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == jmre_pkg::S_FINISH && out_valid_q && !out_ready_i)
      |=> (state_q == jmre_pkg::S_FINISH && $stable(out_q)))
    else $error("Pending result overwritten.");

  a_move_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.result_kind == jmre_pkg::KIND_REPORT)
      |-> (out_data_o.x_move <= $signed({1'b0, speed_lim_q}) &&
           out_data_o.x_move >= -$signed({1'b0, speed_lim_q}) &&
           out_data_o.y_move <= $signed({1'b0, speed_lim_q}) &&
           out_data_o.y_move >= -$signed({1'b0, speed_lim_q})))
    else $error("Reported motion exceeds the speed limit.");
`endif

endmodule

`default_nettype wire

/* verif/tb_joystick_mouse_report_engine_core.sv */
module tb_joystick_mouse_report_engine_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit   = 500000;
  localparam int SettleCycles = 60;
  localparam int PhaseItems   = 70;

  class mouse_report_scoreboard;
    logic [jmre_pkg::BandW-1:0]   dead_band = jmre_pkg::DeadBandRst;
    logic [jmre_pkg::DsrW-1:0]    speed_div = jmre_pkg::SpeedDivRst;
    logic [jmre_pkg::LimW-1:0]    speed_lim = jmre_pkg::SpeedLimRst;
    logic [jmre_pkg::SampleW-1:0] centre_x  = jmre_pkg::CentreRst;
    logic [jmre_pkg::SampleW-1:0] centre_y  = jmre_pkg::CentreRst;
    bit                           calibrated = 1'b0;
    logic [jmre_pkg::SumW-1:0]    sum_x = '0;
    logic [jmre_pkg::SumW-1:0]    sum_y = '0;
    int                           cal_count = 0;
    logic [jmre_pkg::BtnW-1:0]    prev_buttons = '0;
    logic [jmre_pkg::CodeW-1:0]   ring [jmre_pkg::RingDepthDef];
    int                           wr_slot = 0;
    int                           rd_slot = 0;
    jmre_pkg::out_item_t          awaited_results [$];
    int                           mismatch_count = 0;

    function void set_reg(jmre_pkg::cfg_reg_e idx, logic [jmre_pkg::CfgW-1:0] value);
      case (idx)
        jmre_pkg::REG_DEAD_BAND: dead_band = value[jmre_pkg::BandW-1:0];
        jmre_pkg::REG_SPEED_DIV: speed_div = value[jmre_pkg::DsrW-1:0];
        jmre_pkg::REG_SPEED_LIM: speed_lim = value[jmre_pkg::LimW-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    function logic signed [jmre_pkg::MoveW-1:0] axis_move(
        logic [jmre_pkg::SampleW-1:0] sample, logic [jmre_pkg::SampleW-1:0] centre);
      int diff;
      int band;
      int divisor;
      int lim;
      int mv;
      diff    = int'(sample) - int'(centre);
      band    = int'(dead_band);
      divisor = (speed_div == '0) ? 1 : int'(speed_div);
      lim     = int'(speed_lim);
      mv      = 0;
      if (diff < -band) begin
        mv = (diff + band) / divisor;
      end else if (diff > band) begin
        mv = (diff - band) / divisor;
      end
      if (mv > lim) begin
        mv = lim;
      end
      if (mv < -lim) begin
        mv = -lim;
      end
      return mv[jmre_pkg::MoveW-1:0];
    endfunction

    function void push_event(logic [jmre_pkg::CodeW-1:0] code);
      int nxt;
      nxt = (wr_slot + 1) % jmre_pkg::RingDepthDef;
      if (nxt == rd_slot) begin
        return;
      end
      ring[wr_slot] = code;
      wr_slot = nxt;
    endfunction

    function void edge_event(logic now, logic was, logic [jmre_pkg::CodeW-1:0] press_code,
                             logic [jmre_pkg::CodeW-1:0] release_code);
      if (now && !was) begin
        push_event(press_code);
      end else if (!now && was) begin
        push_event(release_code);
      end
    endfunction

    function void note_item(jmre_pkg::in_item_t it);
      jmre_pkg::out_item_t       res;
      logic [jmre_pkg::BtnW-1:0] pressed;
      if (!it.link_ready) begin
        return;
      end
      res = '0;
      if (it.operation == jmre_pkg::OP_DRAIN) begin
        if (rd_slot == wr_slot) begin
          return;
        end
        res.result_kind = jmre_pkg::KIND_EVENT;
        res.event_code  = ring[rd_slot];
        rd_slot = (rd_slot + 1) % jmre_pkg::RingDepthDef;
        awaited_results.push_back(res);
        return;
      end
      if (!calibrated) begin
        sum_x += it.x_sample;
        sum_y += it.y_sample;
        cal_count++;
        if (cal_count >= jmre_pkg::CalSamplesDef) begin
          centre_x   = 12'(sum_x / jmre_pkg::CalSamplesDef);
          centre_y   = 12'(sum_y / jmre_pkg::CalSamplesDef);
          calibrated = 1'b1;
        end
        return;
      end
      pressed = ~{it.middle_level, it.right_level, it.left_level};
      edge_event(pressed[0], prev_buttons[0], jmre_pkg::EvLeftPress,
                 jmre_pkg::EvLeftRelease);
      edge_event(pressed[1], prev_buttons[1], jmre_pkg::EvRightPress,
                 jmre_pkg::EvRightRelease);
      edge_event(pressed[2], prev_buttons[2], jmre_pkg::EvMidPress,
                 jmre_pkg::EvMidRelease);
      prev_buttons = pressed;
      res.result_kind = jmre_pkg::KIND_REPORT;
      res.button_bits = pressed;
      res.x_move      = axis_move(it.x_sample, centre_x);
      res.y_move      = axis_move(it.y_sample, centre_y);
      awaited_results.push_back(res);
    endfunction

    task report(string field, logic [7:0] got, logic [7:0] want);
      mismatch_count++;
      $display("%0t: %s: got %0h, expected %0h", $time, field, got, want);
    endtask

    task check_result(jmre_pkg::out_item_t got);
      jmre_pkg::out_item_t want;
      if (awaited_results.size() == 0) begin
        report("result with none awaited, event_code", got.event_code, 8'h00);
        return;
      end
      want = awaited_results.pop_front();
      if (got.result_kind !== want.result_kind) begin
        report("result_kind", 8'(got.result_kind), 8'(want.result_kind));
      end
      if (got.button_bits !== want.button_bits) begin
        report("button_bits", 8'(got.button_bits), 8'(want.button_bits));
      end
      if (got.x_move !== want.x_move) begin
        report("x_move", 8'(got.x_move), 8'(want.x_move));
      end
      if (got.y_move !== want.y_move) begin
        report("y_move", 8'(got.y_move), 8'(want.y_move));
      end
      if (got.event_code !== want.event_code) begin
        report("event_code", got.event_code, want.event_code);
      end
    endtask
  endclass

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_ready_o;
  jmre_pkg::in_item_t            in_data_i   = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  jmre_pkg::out_item_t           out_data_o;
  logic                          cfg_we_i    = 1'b0;
  logic [jmre_pkg::CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [jmre_pkg::CfgW-1:0]     cfg_data_i  = '0;

  int                  stall_pct   = 25;
  int                  cycle_count = 0;
  logic [2:0]          levels      = 3'b111;
  mouse_report_scoreboard board = new();

  joystick_mouse_report_engine_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      board.check_result(out_data_o);
    end
  end

  function automatic logic [jmre_pkg::SampleW-1:0] clamp12(int v);
    if (v < 0) begin
      return 12'h000;
    end
    if (v > 4095) begin
      return 12'hFFF;
    end
    return 12'(v);
  endfunction

  function automatic logic [jmre_pkg::SampleW-1:0] axis_sample(
      logic [jmre_pkg::SampleW-1:0] centre, int span);
    case ($urandom_range(3))
      0, 1: return clamp12(int'(centre) + int'($urandom_range(2 * span)) - span);
      2: return 12'($urandom);
      default: return $urandom_range(1) ? 12'hFFF : 12'h000;
    endcase
  endfunction

  function automatic jmre_pkg::in_item_t random_item();
    jmre_pkg::in_item_t it;
    int                 span;
    it = '0;
    it.link_ready = ($urandom_range(99) >= 8);
    if ($urandom_range(99) < 30) begin
      it.operation = jmre_pkg::OP_DRAIN;
      {it.x_sample, it.y_sample} = 24'($urandom);
      {it.middle_level, it.right_level, it.left_level} = 3'($urandom);
      return it;
    end
    for (int b = 0; b < 3; b++) begin
      if ($urandom_range(99) < 15) begin
        levels[b] = ~levels[b];
      end
    end
    span = int'(board.dead_band) + 32 + (int'(board.speed_lim) + 4) *
           ((board.speed_div == '0) ? 1 : int'(board.speed_div));
    it.operation  = jmre_pkg::OP_SAMPLE;
    it.x_sample   = axis_sample(board.centre_x, span);
    it.y_sample   = axis_sample(board.centre_y, span);
    {it.middle_level, it.right_level, it.left_level} = levels;
    return it;
  endfunction

  task automatic send_item(input jmre_pkg::in_item_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < stall_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_item(it);
  endtask

  task automatic sample_item(input logic [jmre_pkg::SampleW-1:0] x,
                             input logic [jmre_pkg::SampleW-1:0] y,
                             input logic [2:0] lv);
    jmre_pkg::in_item_t it;
    it = '0;
    it.operation  = jmre_pkg::OP_SAMPLE;
    it.link_ready = 1'b1;
    it.x_sample   = x;
    it.y_sample   = y;
    {it.middle_level, it.right_level, it.left_level} = lv;
    send_item(it);
  endtask

  task automatic drain_item(input logic link);
    jmre_pkg::in_item_t it;
    it = '0;
    it.operation  = jmre_pkg::OP_DRAIN;
    it.link_ready = link;
    send_item(it);
  endtask

  // The sender holds off until every awaited result has come and the block is idle.
  task automatic settle();
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [jmre_pkg::BandW-1:0] band,
                            input logic [jmre_pkg::DsrW-1:0] divisor,
                            input logic [jmre_pkg::LimW-1:0] lim);
    logic [jmre_pkg::CfgW-1:0] data;
    data = band;
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= jmre_pkg::REG_DEAD_BAND;
    cfg_data_i <= data;
    board.set_reg(jmre_pkg::REG_DEAD_BAND, data);
    data = {3'($urandom), divisor};
    @(negedge clk_i);
    cfg_idx_i  <= jmre_pkg::REG_SPEED_DIV;
    cfg_data_i <= data;
    board.set_reg(jmre_pkg::REG_SPEED_DIV, data);
    data = {4'($urandom), lim};
    @(negedge clk_i);
    cfg_idx_i  <= jmre_pkg::REG_SPEED_LIM;
    cfg_data_i <= data;
    board.set_reg(jmre_pkg::REG_SPEED_LIM, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    jmre_pkg::in_item_t it;
    int                 cx;
    int                 cy;
    int                 band;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    it = '0;
    it.operation = jmre_pkg::OP_SAMPLE;
    it.x_sample  = 12'hFFF;
    send_item(it);
    drain_item(1'b0);
    drain_item(1'b1);

    for (int i = 0; i < jmre_pkg::CalSamplesDef; i++) begin
      if (i == 0) begin
        sample_item(12'h000, 12'hFFF, 3'($urandom));
      end else if (i == 1) begin
        sample_item(12'hFFF, 12'h000, 3'($urandom));
      end else begin
        sample_item(12'(1948 + $urandom_range(200)), 12'(1948 + $urandom_range(200)),
                    3'($urandom));
      end
    end

    cx   = int'(board.centre_x);
    cy   = int'(board.centre_y);
    band = int'(board.dead_band);
    sample_item(12'h000, 12'h000, 3'b111);
    sample_item(12'hFFF, 12'hFFF, 3'b111);
    sample_item(board.centre_x, board.centre_y, 3'b111);
    sample_item(clamp12(cx + band), clamp12(cy - band), 3'b111);
    sample_item(clamp12(cx + band + 1), clamp12(cy - band - 1), 3'b111);
    sample_item(clamp12(cx - band - 45), clamp12(cy + band + 45), 3'b110);
    sample_item(clamp12(cx + band + 700), clamp12(cy - band - 700), 3'b100);
    sample_item(board.centre_x, board.centre_y, 3'b000);
    sample_item(board.centre_x, board.centre_y, 3'b111);
    drain_item(1'b0);
    repeat (2) begin
      sample_item(12'($urandom), 12'($urandom), 3'b000);
      sample_item(12'($urandom), 12'($urandom), 3'b111);
    end
    repeat (jmre_pkg::RingDepthDef) drain_item(1'b1);
    levels = 3'b111;
    settle();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: write_regs(11'd0, 8'd1, 7'd127);
        1: write_regs(11'd2047, 8'd255, 7'd0);
        2: write_regs(11'd40, 8'd0, 7'd127);
        3: write_regs(11'd300, 8'd3, 7'd10);
        default: write_regs(11'($urandom_range(400)), 8'($urandom_range(1, 255)),
                            7'($urandom));
      endcase
      stall_pct = (p == 2) ? 0 : 25;
      repeat (PhaseItems) send_item(random_item());
      settle();
    end

    if (board.mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
